@@ sv/hch_pkg.sv @@
package hch_pkg;
   localparam int NumBins     = 9;
   localparam int MaxCellSize = 32;
   localparam int GradW       = 11;
   localparam int MagW        = 15;
   localparam int AccW        = 25;
   localparam int BinW        = 4;
   localparam int CountW      = 11;
   localparam int CfgW        = 6;
   localparam logic [AccW-1:0] AccMax = {AccW{1'b1}};

   // tan of -69,-49,-29,-9,11,31,51,71 degrees, times 10^13, rounded
   localparam int EdgeW = 46;
   localparam logic signed [EdgeW-1:0] TanScale = 46'sd10000000000000;
   typedef logic signed [EdgeW-1:0] edge_tan_type [0:NumBins-2];
   localparam edge_tan_type EdgeTan = '{
      -46'sd26050890646938, -46'sd11503684072210, -46'sd5543090514528,
      -46'sd1583844403245, 46'sd1943803091377, 46'sd6008606190276,
      46'sd12348971565351, 46'sd29042108776758};

   // classified pixel between front and back
   typedef struct packed {
      logic [BinW-1:0] bin;
      logic [MagW-1:0] mag;
      logic            close;
   } pix_type;

   // one result transaction
   typedef struct packed {
      logic [BinW-1:0] bin_index;
      logic [AccW-1:0] bin_sum;
      logic            last_bin;
   } rsp_type;
endpackage

@@ sv/hog_cell_histogram.sv @@
// HOG cell histogram: 9 orientation bins of gradient magnitude per cell.
// req_ channel: one pixel (req_grad_x, req_grad_y) per transaction, cell by
// cell. rsp_ channel: after cell_size^2 pixels (cell_size clamped to 1..32),
// nine transactions, bins 0..8, rsp_last_bin high on bin 8. csr_ channel
// writes cell_size (reset 8); write it only while the block is idle.
// The front end takes no new pixel until the last one is handed to the back
// end; its rate is set by its bit-serial square root (16 iterations) plus the
// load and hand-off states. The back end accumulates each pixel as it is
// handed off, so it holds the front end only while it emits a burst.
// rsp_valid rises on bin 0 once the closing pixel has been added, then one
// bin per cycle while rsp_stall is low. A stalled receiver holds the burst;
// the front end can hold one more classified pixel, with req_stall high.
// Reset (synchronous, active high) clears all bin sums and the pixel count.
module hog_cell_histogram (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [hch_pkg::GradW-1:0]    req_grad_x,
   input  logic signed [hch_pkg::GradW-1:0]    req_grad_y,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic        [hch_pkg::BinW-1:0]     rsp_bin_index,
   output logic        [hch_pkg::AccW-1:0]     rsp_bin_sum,
   output logic                                rsp_last_bin,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic        [hch_pkg::CfgW-1:0]     csr_cell_size
);
   import hch_pkg::*;

   logic [CfgW-1:0] cell_size_ff;
   logic            pix_valid, pix_stall;
   pix_type         pix_data;
   rsp_type         rsp_data;

   // configuration register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_size_ff <= CfgW'(8);
      end else if (csr_valid && csr_ready) begin
         cell_size_ff <= csr_cell_size;
      end
   end

   hch_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_grad_x, .req_grad_y,
      .cell_size(cell_size_ff), .pix_valid, .pix_stall, .pix_data);

   hch_back u_back (
      .clock, .reset, .pix_valid, .pix_stall, .pix_data,
      .rsp_valid, .rsp_stall, .rsp_data);

   assign rsp_bin_index = rsp_data.bin_index;
   assign rsp_bin_sum   = rsp_data.bin_sum;
   assign rsp_last_bin  = rsp_data.last_bin;
endmodule

@@ sv/hch_front.sv @@
module hch_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [hch_pkg::GradW-1:0]    req_grad_x,
   input  logic signed [hch_pkg::GradW-1:0]    req_grad_y,
   input  logic        [hch_pkg::CfgW-1:0]     cell_size,
   output logic                                pix_valid,
   input  logic                                pix_stall,
   output hch_pkg::pix_type                    pix_data
);
   import hch_pkg::*;

   localparam int SqW  = 2*GradW + 8 + 1;
   localparam int Iter = 16;
   localparam int CmpW = GradW + EdgeW + 2;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_ROOT = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [SqW-1:0]     rem_ff, rem_in;
   logic [MagW:0]      root_ff, root_in;
   logic [4:0]         iter_ff, iter_in;
   logic [BinW-1:0]    bin_ff, bin_in;
   logic               close_ff, close_in;
   logic [CountW-1:0]  count_ff, count_in;

   logic [CfgW-1:0]      edge_sz;
   logic [CountW-1:0]    target;
   logic signed [GradW:0] ax, by;
   logic [BinW-1:0]      bin_calc;
   logic [SqW-1:0]       sq_calc;
   logic [SqW-1:0]       trial;
   logic [SqW-1:0]       rem_shift;
   logic                 take;

   assign req_stall = (state_ff != ST_IDLE);
   assign take      = req_valid && !req_stall;
   assign pix_valid = (state_ff == ST_DONE);
   assign pix_data  = '{bin: bin_ff, mag: root_ff[MagW-1:0], close: close_ff};

   // clamp cell edge and square it
   always_comb begin
      edge_sz = cell_size;
      if (edge_sz == '0) edge_sz = CfgW'(1);
      if (edge_sz > CfgW'(MaxCellSize)) edge_sz = CfgW'(MaxCellSize);
      target = CountW'(edge_sz) * CountW'(edge_sz);
   end

   // orientation bin: count thresholds reached
   always_comb begin
      logic signed [CmpW-1:0] lhs, rhs;
      ax = req_grad_x[GradW-1] ? -(GradW+1)'(req_grad_x) : (GradW+1)'(req_grad_x);
      by = req_grad_x[GradW-1] ? -(GradW+1)'(req_grad_y) : (GradW+1)'(req_grad_y);
      bin_calc = '0;
      lhs = CmpW'(by) * CmpW'(TanScale);
      for (int k = 0; k < NumBins-1; k++) begin
         rhs = CmpW'(ax) * CmpW'(EdgeTan[k]);
         if (lhs >= rhs) bin_calc = bin_calc + BinW'(1);
      end
      if (req_grad_x == '0) bin_calc = BinW'(NumBins-1);
      sq_calc = (SqW'(req_grad_x * req_grad_x) + SqW'(req_grad_y * req_grad_y)) << 8;
   end

   // bit-pair square root, one result bit per cycle
   always_comb begin
      rem_shift = rem_ff;
      trial     = SqW'({root_ff, 2'b01});
      state_in  = state_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      iter_in   = iter_ff;
      bin_in    = bin_ff;
      close_in  = close_ff;
      count_in  = count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               rem_in   = sq_calc;
               root_in  = '0;
               iter_in  = '0;
               bin_in   = bin_calc;
               close_in = (count_ff + CountW'(1)) >= target;
               count_in = close_in ? '0 : count_ff + CountW'(1);
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            // remainder window: top bits of the remainder at this step
            rem_shift = SqW'(rem_ff >> (2*(Iter-1) - 2*iter_ff));
            trial     = SqW'({root_ff, 2'b01});
            if (rem_shift >= trial) begin
               rem_in  = rem_ff - SqW'(trial << (2*(Iter-1) - 2*iter_ff));
               root_in = {root_ff[MagW-1:0], 1'b1};
            end else begin
               root_in = {root_ff[MagW-1:0], 1'b0};
            end
            iter_in = iter_ff + 5'd1;
            if (iter_ff == 5'(Iter-1)) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!pix_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      iter_ff  <= iter_in;
      bin_ff   <= bin_in;
      close_ff <= close_in;
   end
endmodule

@@ sv/hch_back.sv @@
module hch_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             pix_valid,
   output logic             pix_stall,
   input  hch_pkg::pix_type pix_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hch_pkg::rsp_type rsp_data
);
   import hch_pkg::*;

   typedef enum logic [1:0] {
      ST_ACC  = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

   state_type          state_ff, state_in;
   logic [AccW-1:0]    acc_ff [0:NumBins-1];
   logic [AccW-1:0]    acc_in [0:NumBins-1];
   logic [BinW-1:0]    emit_ff, emit_in;
   logic [AccW:0]      sum;

   assign pix_stall = (state_ff != ST_ACC);
   assign rsp_valid = (state_ff == ST_EMIT);
   assign rsp_data  = '{bin_index: emit_ff, bin_sum: acc_ff[emit_ff],
                        last_bin: emit_ff == BinW'(NumBins-1)};

   // saturating add, then burst of nine results
   always_comb begin
      state_in = state_ff;
      emit_in  = emit_ff;
      acc_in   = acc_ff;
      sum      = (AccW+1)'(acc_ff[pix_data.bin]) + (AccW+1)'(pix_data.mag);
      case (state_ff)
         ST_ACC: begin
            if (pix_valid) begin
               acc_in[pix_data.bin] = sum[AccW] ? AccMax : sum[AccW-1:0];
               if (pix_data.close) begin
                  emit_in  = '0;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               acc_in[emit_ff] = '0;
               emit_in = emit_ff + BinW'(1);
               if (emit_ff == BinW'(NumBins-1)) state_in = ST_ACC;
            end
         end
         default: state_in = ST_ACC;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACC;
         emit_ff  <= '0;
         for (int k = 0; k < NumBins; k++) acc_ff[k] <= '0;
      end else begin
         state_ff <= state_in;
         emit_ff  <= emit_in;
         acc_ff   <= acc_in;
      end
   end
endmodule

@@ sv/hch_checker.sv @@
module hch_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [3:0] rsp_bin_index,
   input logic       rsp_last_bin
);
   // last flag marks bin 8 only
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_bin == (rsp_bin_index == 4'd8)))
      else $error("last_bin mismatch");
   // bins step by one within a burst
   a_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_bin |=>
      rsp_valid && rsp_bin_index == $past(rsp_bin_index) + 4'd1)
      else $error("bin sequence broken");
   // index stays in range
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_bin_index <= 4'd8)
      else $error("bin index out of range");
   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_bin_index))
      else $error("stalled result changed");
endmodule

bind hog_cell_histogram hch_checker u_checker (
   .clock, .reset, .rsp_valid, .rsp_stall, .rsp_bin_index, .rsp_last_bin);
